@@ rtl/core/cau_pkg.sv @@
package cau_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int FIELD_BITS = 32;
   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int QUO_BITS   = WORD_BITS + 1;
   localparam int PRE_SHIFT  = QUO_BITS - FRAC_BITS;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_NORM = 3'd4;
   localparam logic [2:0] OP_EQ   = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [PROD_BITS-1:0]        mag_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [SUM_BITS-1:0]  sum_type;
   typedef logic [QUO_BITS-1:0]         quo_type;

   typedef struct packed {
      logic [2:0]                   operation;
      logic signed [FIELD_BITS-1:0] a_re;
      logic signed [FIELD_BITS-1:0] a_im;
      logic signed [FIELD_BITS-1:0] b_re;
      logic signed [FIELD_BITS-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] res_re;
      logic signed [FIELD_BITS-1:0] res_im;
      logic                         equal_flag;
      logic [1:0]                   status;
   } rsp_type;

   typedef struct packed {
      logic                         ovf;
      logic signed [FIELD_BITS-1:0] value;
   } sat_type;

   typedef struct packed {
      logic    is_div;
      logic    den_zero;
      mag_type den;
      mag_type rem_re;
      mag_type rem_im;
      quo_type quo_re;
      quo_type quo_im;
      logic    neg_re;
      logic    neg_im;
      logic    big_re;
      logic    big_im;
      rsp_type rsp;
   } pipe_type;

   function automatic word_type field_value(logic [FIELD_BITS-1:0] raw);
      return word_type'(raw[WORD_BITS-1:0]);
   endfunction

   // Saturates a sign and magnitude pair to the word range.
   function automatic sat_type sat_mag(logic neg, mag_type mag);
      mag_type  lim;
      word_type w;
      sat_type  r;
      lim   = mag_type'(1) << (WORD_BITS - 1);
      r.ovf = 1'b0;
      if (!neg) begin
         if (mag > lim - mag_type'(1)) begin
            r.ovf = 1'b1;
            w     = {1'b0, {(WORD_BITS-1){1'b1}}};
         end else begin
            w = word_type'(mag[WORD_BITS-1:0]);
         end
      end else begin
         if (mag > lim) begin
            r.ovf = 1'b1;
            w     = {1'b1, {(WORD_BITS-1){1'b0}}};
         end else begin
            w = -word_type'(mag[WORD_BITS-1:0]);
         end
      end
      r.value = FIELD_BITS'(w);
      return r;
   endfunction

   function automatic sat_type sat_sum(logic signed [WORD_BITS:0] s);
      logic signed [WORD_BITS:0] hi;
      logic signed [WORD_BITS:0] lo;
      word_type                  w;
      sat_type                   r;
      hi    = {2'b00, {(WORD_BITS-1){1'b1}}};
      lo    = {2'b11, {(WORD_BITS-1){1'b0}}};
      r.ovf = 1'b0;
      if (s > hi) begin
         r.ovf = 1'b1;
         w     = word_type'(hi[WORD_BITS-1:0]);
      end else if (s < lo) begin
         r.ovf = 1'b1;
         w     = word_type'(lo[WORD_BITS-1:0]);
      end else begin
         w = word_type'(s[WORD_BITS-1:0]);
      end
      r.value = FIELD_BITS'(w);
      return r;
   endfunction

endpackage

@@ rtl/core/cau_front.sv @@
module cau_front import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  logic     in_valid,
   input  req_type  in_word,
   output logic     out_valid,
   output pipe_type out_pipe
);

   logic       a_valid_ff;
   logic [2:0] a_op_ff;
   word_type   a_ar_ff, a_ai_ff, a_br_ff, a_bi_ff;

   logic       b_valid_ff;
   logic [2:0] b_op_ff;
   prod_type   b_prr_ff, b_pii_ff, b_pri_ff, b_pir_ff, b_dr_ff, b_di_ff;
   prod_type   b_prr_in, b_pii_in, b_pri_in, b_pir_in, b_dr_in, b_di_in;
   rsp_type    b_rsp_ff, b_rsp_in;
   word_type   mul_x, mul_y;

   logic       c_valid_ff;
   logic [2:0] c_op_ff;
   sum_type    c_re_ff, c_im_ff, c_re_in, c_im_in;
   mag_type    c_den_ff;
   rsp_type    c_rsp_ff;

   logic       d_valid_ff;
   logic [2:0] d_op_ff;
   logic       d_neg_re_ff, d_neg_im_ff;
   mag_type    d_mag_re_ff, d_mag_im_ff, d_den_ff;
   rsp_type    d_rsp_ff;

   logic       e_valid_ff;
   pipe_type   e_pipe_ff, e_pipe_in;

   always_comb begin
      sat_type s_re;
      sat_type s_im;
      s_re     = '0;
      s_im     = '0;
      b_rsp_in = '0;
      case (a_op_ff)
         OP_ADD: begin
            s_re = sat_sum((WORD_BITS+1)'(a_ar_ff) + (WORD_BITS+1)'(a_br_ff));
            s_im = sat_sum((WORD_BITS+1)'(a_ai_ff) + (WORD_BITS+1)'(a_bi_ff));
         end
         OP_SUB: begin
            s_re = sat_sum((WORD_BITS+1)'(a_ar_ff) - (WORD_BITS+1)'(a_br_ff));
            s_im = sat_sum((WORD_BITS+1)'(a_ai_ff) - (WORD_BITS+1)'(a_bi_ff));
         end
         OP_EQ: begin
            b_rsp_in.equal_flag = (a_ar_ff == a_br_ff) && (a_ai_ff == a_bi_ff);
         end
         default: begin
         end
      endcase
      if (a_op_ff == OP_ADD || a_op_ff == OP_SUB) begin
         b_rsp_in.res_re = s_re.value;
         b_rsp_in.res_im = s_im.value;
         b_rsp_in.status = (s_re.ovf || s_im.ovf) ? ST_SAT : ST_OK;
      end
   end

   assign mul_x    = (a_op_ff == OP_NORM) ? a_ar_ff : a_br_ff;
   assign mul_y    = (a_op_ff == OP_NORM) ? a_ai_ff : a_bi_ff;
   assign b_prr_in = PROD_BITS'(a_ar_ff) * PROD_BITS'(mul_x);
   assign b_pii_in = PROD_BITS'(a_ai_ff) * PROD_BITS'(mul_y);
   assign b_pri_in = PROD_BITS'(a_ar_ff) * PROD_BITS'(a_bi_ff);
   assign b_pir_in = PROD_BITS'(a_ai_ff) * PROD_BITS'(a_br_ff);
   assign b_dr_in  = PROD_BITS'(a_br_ff) * PROD_BITS'(a_br_ff);
   assign b_di_in  = PROD_BITS'(a_bi_ff) * PROD_BITS'(a_bi_ff);

   always_comb begin
      c_re_in = '0;
      c_im_in = '0;
      case (b_op_ff)
         OP_MUL: begin
            c_re_in = SUM_BITS'(b_prr_ff) - SUM_BITS'(b_pii_ff);
            c_im_in = SUM_BITS'(b_pri_ff) + SUM_BITS'(b_pir_ff);
         end
         OP_DIV: begin
            c_re_in = SUM_BITS'(b_prr_ff) + SUM_BITS'(b_pii_ff);
            c_im_in = SUM_BITS'(b_pir_ff) - SUM_BITS'(b_pri_ff);
         end
         OP_NORM: begin
            c_re_in = SUM_BITS'(b_prr_ff) + SUM_BITS'(b_pii_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sat_type s_re;
      sat_type s_im;
      mag_type top_re;
      mag_type top_im;
      s_re   = sat_mag(d_neg_re_ff, d_mag_re_ff >> FRAC_BITS);
      s_im   = sat_mag(d_neg_im_ff, d_mag_im_ff >> FRAC_BITS);
      top_re = d_mag_re_ff >> PRE_SHIFT;
      top_im = d_mag_im_ff >> PRE_SHIFT;
      e_pipe_in          = '0;
      e_pipe_in.is_div   = (d_op_ff == OP_DIV);
      e_pipe_in.den_zero = (d_den_ff == '0);
      e_pipe_in.den      = d_den_ff;
      e_pipe_in.neg_re   = d_neg_re_ff;
      e_pipe_in.neg_im   = d_neg_im_ff;
      e_pipe_in.big_re   = (top_re >= d_den_ff);
      e_pipe_in.big_im   = (top_im >= d_den_ff);
      e_pipe_in.rem_re   = top_re;
      e_pipe_in.rem_im   = top_im;
      e_pipe_in.quo_re   = {d_mag_re_ff[PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      e_pipe_in.quo_im   = {d_mag_im_ff[PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      case (d_op_ff)
         OP_MUL: begin
            e_pipe_in.rsp.res_re = s_re.value;
            e_pipe_in.rsp.res_im = s_im.value;
            e_pipe_in.rsp.status = (s_re.ovf || s_im.ovf) ? ST_SAT : ST_OK;
         end
         OP_NORM: begin
            e_pipe_in.rsp.res_re = s_re.value;
            e_pipe_in.rsp.status = s_re.ovf ? ST_SAT : ST_OK;
         end
         default: begin
            e_pipe_in.rsp = d_rsp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_op_ff     <= in_word.operation;
         a_ar_ff     <= field_value(in_word.a_re);
         a_ai_ff     <= field_value(in_word.a_im);
         a_br_ff     <= field_value(in_word.b_re);
         a_bi_ff     <= field_value(in_word.b_im);
         b_op_ff     <= a_op_ff;
         b_prr_ff    <= b_prr_in;
         b_pii_ff    <= b_pii_in;
         b_pri_ff    <= b_pri_in;
         b_pir_ff    <= b_pir_in;
         b_dr_ff     <= b_dr_in;
         b_di_ff     <= b_di_in;
         b_rsp_ff    <= b_rsp_in;
         c_op_ff     <= b_op_ff;
         c_re_ff     <= c_re_in;
         c_im_ff     <= c_im_in;
         c_den_ff    <= mag_type'(b_dr_ff) + mag_type'(b_di_ff);
         c_rsp_ff    <= b_rsp_ff;
         d_op_ff     <= c_op_ff;
         d_neg_re_ff <= c_re_ff[SUM_BITS-1];
         d_neg_im_ff <= c_im_ff[SUM_BITS-1];
         d_mag_re_ff <= c_re_ff[SUM_BITS-1] ? PROD_BITS'(-c_re_ff) : PROD_BITS'(c_re_ff);
         d_mag_im_ff <= c_im_ff[SUM_BITS-1] ? PROD_BITS'(-c_im_ff) : PROD_BITS'(c_im_ff);
         d_den_ff    <= c_den_ff;
         d_rsp_ff    <= c_rsp_ff;
         e_pipe_ff   <= e_pipe_in;
      end
   end

   assign out_valid = e_valid_ff;
   assign out_pipe  = e_pipe_ff;

endmodule

@@ rtl/core/cau_div_stage.sv @@
module cau_div_stage import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  logic     in_valid,
   input  pipe_type in_pipe,
   output logic     out_valid,
   output pipe_type out_pipe
);

   logic     valid_ff;
   pipe_type pipe_ff, pipe_in;

   always_comb begin
      mag_type part_re;
      mag_type part_im;
      logic    take_re;
      logic    take_im;
      part_re = {in_pipe.rem_re[PROD_BITS-2:0], in_pipe.quo_re[QUO_BITS-1]};
      part_im = {in_pipe.rem_im[PROD_BITS-2:0], in_pipe.quo_im[QUO_BITS-1]};
      take_re = (part_re >= in_pipe.den);
      take_im = (part_im >= in_pipe.den);
      pipe_in        = in_pipe;
      pipe_in.rem_re = take_re ? part_re - in_pipe.den : part_re;
      pipe_in.rem_im = take_im ? part_im - in_pipe.den : part_im;
      pipe_in.quo_re = {in_pipe.quo_re[QUO_BITS-2:0], take_re};
      pipe_in.quo_im = {in_pipe.quo_im[QUO_BITS-2:0], take_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pipe_ff <= pipe_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

@@ rtl/core/complex_arithmetic_unit.sv @@
// Fully pipelined complex ALU on signed Q16.16 operands: add, subtract, multiply, divide,
// squared norm and equality. One word is taken every cycle unless the pipeline stalls.
// Each word passes operand capture, the six multipliers, combining, magnitude and
// saturation, then the 33-bit restoring divider that all operations pass through, each of
// its stages giving one quotient bit, then the output register. A result-side stall
// freezes the whole pipeline; a one-word input skid buffer keeps req_stall registered.
module complex_arithmetic_unit import cau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   logic     enable;
   logic     accept;
   logic     skid_valid_ff, skid_valid_in;
   req_type  skid_word_ff;
   logic     front_in_valid;
   req_type  front_in_word;
   logic     rsp_valid_ff;
   rsp_type  rsp_word_ff, rsp_word_in;

   logic     stage_valid [QUO_BITS+1];
   pipe_type stage_pipe  [QUO_BITS+1];

   assign enable         = !(rsp_valid_ff && rsp_stall);
   assign accept         = req_valid && !skid_valid_ff;
   assign front_in_valid = skid_valid_ff || accept;
   assign front_in_word  = skid_valid_ff ? skid_word_ff : req_word;
   assign skid_valid_in  = enable ? 1'b0 : (skid_valid_ff || accept);

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (front_in_valid),
      .in_word   (front_in_word),
      .out_valid (stage_valid[0]),
      .out_pipe  (stage_pipe[0])
   );

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
      cau_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (stage_valid[i]),
         .in_pipe   (stage_pipe[i]),
         .out_valid (stage_valid[i+1]),
         .out_pipe  (stage_pipe[i+1])
      );
   end

   always_comb begin
      pipe_type p;
      sat_type  s_re;
      sat_type  s_im;
      p    = stage_pipe[QUO_BITS];
      s_re = sat_mag(p.neg_re, p.big_re ? '1 : mag_type'(p.quo_re));
      s_im = sat_mag(p.neg_im, p.big_im ? '1 : mag_type'(p.quo_im));
      rsp_word_in = p.rsp;
      if (p.is_div) begin
         rsp_word_in = '0;
         if (p.den_zero) begin
            rsp_word_in.status = ST_DIV0;
         end else begin
            rsp_word_in.res_re = s_re.value;
            rsp_word_in.res_im = s_im.value;
            rsp_word_in.status = (s_re.ovf || s_im.ovf) ? ST_SAT : ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
         if (enable) begin
            rsp_valid_ff <= stage_valid[QUO_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_word_ff <= req_word;
      end
      if (enable) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
